[design/gddn_pkg.sv]
`default_nettype none
package gddn_pkg;

    localparam int unsigned CW = 22;   // day count / accumulator width

    typedef struct packed {
        logic [CW-1:0] a;     // minuend / compare left side
        logic [CW-1:0] b;     // subtrahend / compare right side
        logic [CW-1:0] c;     // accumulator
        logic [CW-1:0] d;     // accumulator addend
    } alu_in_t;

    typedef struct packed {
        logic [CW-1:0] diff;
        logic [CW-1:0] sum;
        logic          ge;
    } alu_out_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NEG     = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    localparam logic [13:0]   YEAR_FIRST  = 14'd1900;
    localparam logic [13:0]   YEAR_LAST   = 14'd9999;
    localparam logic [CW-1:0] YEAR_BASE   = 22'd1601;
    localparam logic [CW-1:0] COUNT_LIMIT = 22'd2958464;
    // days from 1601-01-01 to 1900-01-01
    localparam logic [CW-1:0] DAY_BIAS    = 22'd109207;
    localparam logic [CW-1:0] DAY_BIAS_P1 = 22'd109208;
    localparam logic [3:0]    LAST_STEP   = 4'd13;
    localparam logic [3:0]    MONTH_DEC   = 4'd12;

    // Restoring-division weights in days: 400 y x16..x1, 100 y x2,x1, 4 y x16..x1, 1 y x2,x1
    function automatic logic [CW-1:0] step_day_w(input logic [3:0] s);
        logic [CW-1:0] w;
        case (s)
            4'd0:    w = 22'd2337552;
            4'd1:    w = 22'd1168776;
            4'd2:    w = 22'd584388;
            4'd3:    w = 22'd292194;
            4'd4:    w = 22'd146097;
            4'd5:    w = 22'd73048;
            4'd6:    w = 22'd36524;
            4'd7:    w = 22'd23376;
            4'd8:    w = 22'd11688;
            4'd9:    w = 22'd5844;
            4'd10:   w = 22'd2922;
            4'd11:   w = 22'd1461;
            4'd12:   w = 22'd730;
            4'd13:   w = 22'd365;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Same steps in years
    function automatic logic [CW-1:0] step_year_w(input logic [3:0] s);
        logic [CW-1:0] w;
        case (s)
            4'd0:    w = 22'd6400;
            4'd1:    w = 22'd3200;
            4'd2:    w = 22'd1600;
            4'd3:    w = 22'd800;
            4'd4:    w = 22'd400;
            4'd5:    w = 22'd200;
            4'd6:    w = 22'd100;
            4'd7:    w = 22'd64;
            4'd8:    w = 22'd32;
            4'd9:    w = 22'd16;
            4'd10:   w = 22'd8;
            4'd11:   w = 22'd4;
            4'd12:   w = 22'd2;
            4'd13:   w = 22'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // Quotient bits, first step in bit 13. Year is leap when the 1-year quotient is 3,
    // unless it closes a century that is not the fourth of its 400-year cycle.
    function automatic logic leap_from_q(input logic [13:0] q);
        return (q[1:0] == 2'b11) && ((q[6:2] != 5'd24) || (q[8:7] == 2'b11));
    endfunction

endpackage
`default_nettype wire

[design/gddn_alu.sv]
`default_nettype none
module gddn_alu (
    input  wire gddn_pkg::alu_in_t alu_in,
    output gddn_pkg::alu_out_t     alu_out
);
    import gddn_pkg::*;

    logic [CW:0] sub_full;

    assign sub_full     = {1'b0, alu_in.a} - {1'b0, alu_in.b};
    assign alu_out.diff = sub_full[CW-1:0];
    assign alu_out.ge   = ~sub_full[CW];
    assign alu_out.sum  = alu_in.c + alu_in.d;

endmodule
`default_nettype wire

[design/gregorian_date_day_number_convert_core.sv]
// Sequence: a count out of range, or a date whose year or month is out of range, is answered
//   from the check state; otherwise a check step, 14 year steps and 1 to 12 month steps run on
//   the shared subtract/compare unit; a finished result waits while the output register is full.
// Flow: one transaction at a time; tready is high only while the sequencer is idle, the
//   output register holds a result until it is taken.
// Reset: rst_n asynchronous active low; clears the sequencer and the output valid flag.
`default_nettype none
module gregorian_date_day_number_convert_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [5:0] day, [9:6] month, [23:10] year, [46:24] day_count, [47] zero
    input  wire logic [47:0] s_axis_tdata,
    // [0] command
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [21:0] out_day_count, [26:22] out_day, [30:27] out_month, [44:31] out_year, [47:45] zero
    output logic [47:0]      m_axis_tdata,
    // [1:0] status
    output logic [1:0]       m_axis_tuser
);
    import gddn_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHK   = 2'd1;
    localparam logic [1:0] S_YEAR  = 2'd2;
    localparam logic [1:0] S_MONTH = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [3:0]    step_reg, step_next;
    logic [3:0]    mon_reg, mon_next;
    logic [CW-1:0] opnd_reg, opnd_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [13:0]   q_reg, q_next;
    logic          cmd_reg, cmd_next;
    logic [5:0]    day_reg, day_next;
    logic [3:0]    month_reg, month_next;
    logic [13:0]   year_reg, year_next;
    logic [22:0]   raw_reg, raw_next;

    logic          mvalid_reg, mvalid_next;
    logic [1:0]    ostat_reg;
    logic [CW-1:0] ocnt_reg;
    logic [4:0]    oday_reg;
    logic [3:0]    omon_reg;
    logic [13:0]   oyear_reg;

    alu_in_t       alu_in;
    alu_out_t      alu_out;

    logic          done;
    logic          out_free;
    logic          leap;
    logic [4:0]    len;
    logic [1:0]    res_stat;
    logic [CW-1:0] res_cnt;
    logic [4:0]    res_day;
    logic [3:0]    res_mon;
    logic [13:0]   res_year;

    gddn_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    assign out_free      = ~mvalid_reg | m_axis_tready;
    assign leap          = leap_from_q(q_reg);
    assign len           = month_len(mon_reg, leap);
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mon_next   = mon_reg;
        opnd_next  = opnd_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        cmd_next   = cmd_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        raw_next   = raw_reg;
        alu_in     = '0;
        done       = 1'b0;
        res_stat   = ST_OK;
        res_cnt    = '0;
        res_day    = '0;
        res_mon    = '0;
        res_year   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = s_axis_tuser[0];
                    day_next   = s_axis_tdata[5:0];
                    month_next = s_axis_tdata[9:6];
                    year_next  = s_axis_tdata[23:10];
                    raw_next   = s_axis_tdata[46:24];
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                q_next    = '0;
                step_next = '0;
                if (!cmd_reg)
                begin
                    alu_in.a = {8'd0, year_reg};
                    alu_in.b = YEAR_BASE;
                    if (!(year_reg inside {[YEAR_FIRST:YEAR_LAST]}) ||
                        !(month_reg inside {[4'd1:MONTH_DEC]}))
                    begin
                        done     = 1'b1;
                        res_stat = ST_INVALID;
                    end
                    else
                    begin
                        opnd_next  = alu_out.diff;   // years since 1601
                        acc_next   = '0;
                        state_next = S_YEAR;
                    end
                end
                else
                begin
                    alu_in.a = raw_reg[CW-1:0];
                    alu_in.b = COUNT_LIMIT;
                    alu_in.c = raw_reg[CW-1:0];
                    alu_in.d = DAY_BIAS;
                    if (raw_reg[22])
                    begin
                        done     = 1'b1;
                        res_stat = ST_NEG;
                    end
                    else if (alu_out.ge)
                    begin
                        done     = 1'b1;
                        res_stat = ST_OVER;
                    end
                    else
                    begin
                        opnd_next  = alu_out.sum;    // days since 1601-01-01
                        acc_next   = YEAR_BASE;
                        state_next = S_YEAR;
                    end
                end
            end
            S_YEAR:
            begin
                // subtract in one unit, credit the matching weight of the other unit
                alu_in.a = opnd_reg;
                alu_in.b = cmd_reg ? step_day_w(step_reg) : step_year_w(step_reg);
                alu_in.c = acc_reg;
                alu_in.d = cmd_reg ? step_year_w(step_reg) : step_day_w(step_reg);
                if (alu_out.ge)
                begin
                    opnd_next = alu_out.diff;
                    acc_next  = alu_out.sum;
                end
                q_next = {q_reg[12:0], alu_out.ge};
                if (step_reg == LAST_STEP)
                begin
                    mon_next   = 4'd1;
                    state_next = S_MONTH;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_MONTH:
            begin
                if (cmd_reg)
                begin
                    alu_in.a = opnd_reg;
                    alu_in.b = {17'd0, len};
                    if ((mon_reg < MONTH_DEC) && alu_out.ge)
                    begin
                        opnd_next = alu_out.diff;
                        mon_next  = mon_reg + 4'd1;
                    end
                    else
                    begin
                        done     = 1'b1;
                        res_day  = opnd_reg[4:0] + 5'd1;
                        res_mon  = mon_reg;
                        res_year = acc_reg[13:0];
                    end
                end
                else if (mon_reg < month_reg)
                begin
                    alu_in.c = acc_reg;
                    alu_in.d = {17'd0, len};
                    acc_next = alu_out.sum;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    // count = acc + (day - 1) - bias
                    alu_in.a = acc_reg;
                    alu_in.b = DAY_BIAS_P1 - {16'd0, day_reg};
                    done     = 1'b1;
                    if ((day_reg == 6'd0) || (day_reg > {1'b0, month_len(month_reg, leap)}))
                    begin
                        res_stat = ST_INVALID;
                    end
                    else
                    begin
                        res_cnt = alu_out.diff;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a finished result waits here until the output register frees up
        if (done && !out_free)
        begin
            state_next = state_reg;
            opnd_next  = opnd_reg;
            acc_next   = acc_reg;
            mon_next   = mon_reg;
            q_next     = q_reg;
            step_next  = step_reg;
        end
        else if (done)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end
        if (done && out_free)
        begin
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        mon_reg   <= mon_next;
        opnd_reg  <= opnd_next;
        acc_reg   <= acc_next;
        q_reg     <= q_next;
        cmd_reg   <= cmd_next;
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        raw_reg   <= raw_next;
        if (done && out_free)
        begin
            ostat_reg <= res_stat;
            ocnt_reg  <= res_cnt;
            oday_reg  <= res_day;
            omon_reg  <= res_mon;
            oyear_reg <= res_year;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tuser  = ostat_reg;
    assign m_axis_tdata  = {3'd0, oyear_reg, omon_reg, oday_reg, ocnt_reg};

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 48'd0))
        else $error("error result carries nonzero data");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR) |-> (step_reg <= LAST_STEP))
        else $error("year step counter out of range");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> ((mon_reg >= 4'd1) && (mon_reg <= MONTH_DEC)))
        else $error("month counter out of range");

    a_accept_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_CHK))
        else $error("accepted transaction did not enter check");

    a_ok_month: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_OK) && (m_axis_tdata[21:0] == 22'd0)
         && (m_axis_tdata[30:27] != 4'd0)) |-> (m_axis_tdata[26:22] != 5'd0))
        else $error("date result with zero day");
`endif

endmodule
`default_nettype wire
